>>> sv/qrm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrm_pkg
// Shared widths and the inter-stage word of the quaternion to matrix pipe.
// ---------------------------------------------------------------------------
package qrm_pkg;

  localparam int NUM_EL  = 9;   // matrix elements, row major
  localparam int IN_W    = 16;  // Q1.14 input component
  localparam int PROD_W  = 32;  // 16x16 signed product
  localparam int NORM_W  = 33;  // sum of four squares, up to 2^32
  localparam int REM_W   = 34;  // partial remainder, below 2 * norm
  localparam int QUO_W   = 16;  // floor(mag * 2^15 / norm), up to 2^15
  localparam int OUT_W   = 16;  // Q1.14 result element
  localparam int ONE_Q14 = 16384;

  // word carried through the division steps
  typedef struct packed {
    logic [NUM_EL-1:0][REM_W-1:0] rem;
    logic [NUM_EL-1:0][QUO_W-1:0] quo;
    logic [NUM_EL-1:0]            neg;
    logic [NORM_W-1:0]            norm;
    logic                         zero;
  } div_word_t;

endpackage

>>> sv/quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Pipeline of 3 front stages, 16 one-bit division steps and 1 output stage from
// the start input to the done strobe. Throughput: one word per cycle;
// busy stays low. Reset clears the valid bits of every stage; data is not reset.
// The receiver cannot stall, so no word is ever held back.
// ---------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [qrm_pkg::IN_W-1:0] qx,
  input  logic signed [qrm_pkg::IN_W-1:0] qy,
  input  logic signed [qrm_pkg::IN_W-1:0] qz,
  input  logic signed [qrm_pkg::IN_W-1:0] qw,
  output logic                            done,
  output logic signed [qrm_pkg::OUT_W-1:0] m00,
  output logic signed [qrm_pkg::OUT_W-1:0] m01,
  output logic signed [qrm_pkg::OUT_W-1:0] m02,
  output logic signed [qrm_pkg::OUT_W-1:0] m10,
  output logic signed [qrm_pkg::OUT_W-1:0] m11,
  output logic signed [qrm_pkg::OUT_W-1:0] m12,
  output logic signed [qrm_pkg::OUT_W-1:0] m20,
  output logic signed [qrm_pkg::OUT_W-1:0] m21,
  output logic signed [qrm_pkg::OUT_W-1:0] m22,
  output logic                            norm_zero
);

  logic                                   step_valid [qrm_pkg::QUO_W+1];
  qrm_pkg::div_word_t                     step_word  [qrm_pkg::QUO_W+1];
  logic signed [qrm_pkg::NUM_EL-1:0][qrm_pkg::OUT_W-1:0] el;

  assign busy = 1'b0;

  qrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .qw        (qw),
    .out_valid (step_valid[0]),
    .out_word  (step_word[0])
  );

  for (genvar s = 0; s < qrm_pkg::QUO_W; s++) begin : g_step
    qrm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (step_valid[s]),
      .in_word   (step_word[s]),
      .out_valid (step_valid[s+1]),
      .out_word  (step_word[s+1])
    );
  end

  qrm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (step_valid[qrm_pkg::QUO_W]),
    .in_word   (step_word[qrm_pkg::QUO_W]),
    .out_valid (done),
    .out_el    (el),
    .out_zero  (norm_zero)
  );

  assign m00 = el[0];
  assign m01 = el[1];
  assign m02 = el[2];
  assign m10 = el[3];
  assign m11 = el[4];
  assign m12 = el[5];
  assign m20 = el[6];
  assign m21 = el[7];
  assign m22 = el[8];

endmodule

>>> sv/qrm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrm_front
// Products, numerator sums and magnitudes: three register stages that
// turn a quaternion into the word the division steps work on.
// ---------------------------------------------------------------------------
module qrm_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [qrm_pkg::IN_W-1:0]    qx,
  input  logic signed [qrm_pkg::IN_W-1:0]    qy,
  input  logic signed [qrm_pkg::IN_W-1:0]    qz,
  input  logic signed [qrm_pkg::IN_W-1:0]    qw,
  output logic                               out_valid,
  output qrm_pkg::div_word_t                 out_word
);

  // stage 1: ten products
  logic                                 v1;
  logic signed [qrm_pkg::PROD_W-1:0]    p_xx, p_yy, p_zz, p_ww;
  logic signed [qrm_pkg::PROD_W-1:0]    p_xy, p_zw, p_zx, p_yw, p_yz, p_xw;

  // stage 2: norm and signed numerators (off-diagonal ones doubled)
  logic                                 v2;
  logic [qrm_pkg::NORM_W-1:0]           norm2;
  logic signed [qrm_pkg::REM_W-1:0]     num2 [qrm_pkg::NUM_EL];

  logic signed [qrm_pkg::REM_W-1:0]     e_xx, e_yy, e_zz, e_ww;
  logic signed [qrm_pkg::REM_W-1:0]     e_xy, e_zw, e_zx, e_yw, e_yz, e_xw;
  logic signed [qrm_pkg::REM_W-1:0]     sum_n;

  always_comb begin
    e_xx  = qrm_pkg::REM_W'(p_xx);
    e_yy  = qrm_pkg::REM_W'(p_yy);
    e_zz  = qrm_pkg::REM_W'(p_zz);
    e_ww  = qrm_pkg::REM_W'(p_ww);
    e_xy  = qrm_pkg::REM_W'(p_xy);
    e_zw  = qrm_pkg::REM_W'(p_zw);
    e_zx  = qrm_pkg::REM_W'(p_zx);
    e_yw  = qrm_pkg::REM_W'(p_yw);
    e_yz  = qrm_pkg::REM_W'(p_yz);
    e_xw  = qrm_pkg::REM_W'(p_xw);
    sum_n = e_xx + e_yy + e_zz + e_ww;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p_xx <= qx * qx;
    p_yy <= qy * qy;
    p_zz <= qz * qz;
    p_ww <= qw * qw;
    p_xy <= qx * qy;
    p_zw <= qz * qw;
    p_zx <= qz * qx;
    p_yw <= qy * qw;
    p_yz <= qy * qz;
    p_xw <= qx * qw;
  end

  always_ff @(posedge clk) begin
    norm2   <= sum_n[qrm_pkg::NORM_W-1:0];
    num2[0] <= e_ww + e_xx - e_yy - e_zz;
    num2[1] <= (e_xy - e_zw) <<< 1;
    num2[2] <= (e_zx + e_yw) <<< 1;
    num2[3] <= (e_xy + e_zw) <<< 1;
    num2[4] <= e_ww + e_yy - e_xx - e_zz;
    num2[5] <= (e_yz - e_xw) <<< 1;
    num2[6] <= (e_zx - e_yw) <<< 1;
    num2[7] <= (e_yz + e_xw) <<< 1;
    num2[8] <= e_ww + e_zz - e_xx - e_yy;
  end

  // stage 3: split into sign and magnitude, seed the remainder
  always_ff @(posedge clk) begin
    for (int e = 0; e < qrm_pkg::NUM_EL; e++) begin
      out_word.neg[e] <= num2[e][qrm_pkg::REM_W-1];
      out_word.rem[e] <= num2[e][qrm_pkg::REM_W-1] ? -num2[e] : num2[e];
      out_word.quo[e] <= '0;
    end
    out_word.norm <= norm2;
    out_word.zero <= (norm2 == '0);
  end

endmodule

>>> sv/qrm_div_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrm_div_step
// One restoring division step for all nine elements: one quotient bit each.
// ---------------------------------------------------------------------------
module qrm_div_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  qrm_pkg::div_word_t in_word,
  output logic               out_valid,
  output qrm_pkg::div_word_t out_word
);

  qrm_pkg::div_word_t word_next;
  logic [qrm_pkg::REM_W-1:0] norm_ext;
  logic [qrm_pkg::REM_W-1:0] diff;

  always_comb begin
    word_next = in_word;
    norm_ext  = qrm_pkg::REM_W'(in_word.norm);
    diff      = '0;
    for (int e = 0; e < qrm_pkg::NUM_EL; e++) begin
      // subtract when the remainder covers the divisor, then shift for the next bit
      if (in_word.rem[e] >= norm_ext) begin
        diff = in_word.rem[e] - norm_ext;
        word_next.quo[e] = {in_word.quo[e][qrm_pkg::QUO_W-2:0], 1'b1};
      end else begin
        diff = in_word.rem[e];
        word_next.quo[e] = {in_word.quo[e][qrm_pkg::QUO_W-2:0], 1'b0};
      end
      word_next.rem[e] = {diff[qrm_pkg::REM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

>>> sv/qrm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrm_back
// Round half away from zero, clamp to +-1.0, restore sign, and substitute
// the identity matrix for a zero quaternion.
// ---------------------------------------------------------------------------
module qrm_back (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  qrm_pkg::div_word_t                       in_word,
  output logic                                     out_valid,
  output logic signed [qrm_pkg::NUM_EL-1:0][qrm_pkg::OUT_W-1:0] out_el,
  output logic                                     out_zero
);

  logic [qrm_pkg::QUO_W:0]   rnd;
  logic [qrm_pkg::OUT_W-1:0] mag;
  logic [qrm_pkg::NUM_EL-1:0][qrm_pkg::OUT_W-1:0] el_next;

  always_comb begin
    rnd = '0;
    mag = '0;
    for (int e = 0; e < qrm_pkg::NUM_EL; e++) begin
      // quotient holds one extra fraction bit: add half and drop it
      rnd = qrm_pkg::QUO_W'(in_word.quo[e]) + (qrm_pkg::QUO_W + 1)'(1);
      mag = rnd[qrm_pkg::QUO_W:1];
      if (mag > qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14)) begin
        mag = qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14);
      end
      if (in_word.zero) begin
        el_next[e] = (e % 4 == 0) ? qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14) : '0;
      end else begin
        el_next[e] = in_word.neg[e] ? -mag : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_el   <= el_next;
    out_zero <= in_word.zero;
  end

endmodule

>>> bench/qrm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qrm_checker
// Watches the quaternion and matrix channels of quaternion_to_rotation_matrix,
// predicts each matrix word from the accepted quaternion and compares them in
// order, field by field. Hands its counts of failures and checks to the top.
// ---------------------------------------------------------------------------
module qrm_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic signed [qrm_pkg::IN_W-1:0] qx,
  input  logic signed [qrm_pkg::IN_W-1:0] qy,
  input  logic signed [qrm_pkg::IN_W-1:0] qz,
  input  logic signed [qrm_pkg::IN_W-1:0] qw,
  input  logic                            done,
  input  logic signed [qrm_pkg::OUT_W-1:0] m00,
  input  logic signed [qrm_pkg::OUT_W-1:0] m01,
  input  logic signed [qrm_pkg::OUT_W-1:0] m02,
  input  logic signed [qrm_pkg::OUT_W-1:0] m10,
  input  logic signed [qrm_pkg::OUT_W-1:0] m11,
  input  logic signed [qrm_pkg::OUT_W-1:0] m12,
  input  logic signed [qrm_pkg::OUT_W-1:0] m20,
  input  logic signed [qrm_pkg::OUT_W-1:0] m21,
  input  logic signed [qrm_pkg::OUT_W-1:0] m22,
  input  logic                            norm_zero,
  output int                              errors,
  output int                              checked,
  output int                              zeros,
  output int                              pending
);

  typedef struct packed {
    logic [qrm_pkg::NUM_EL-1:0][qrm_pkg::OUT_W-1:0] el;   // row major, el[0] is m00
    logic                                           zero;
  } matrix_t;

  matrix_t expected_matrices[$];

  // num * scale / den rounded to nearest, ties away from zero, clamped to +-1.0
  function automatic logic signed [qrm_pkg::OUT_W-1:0] round_ratio_q14(longint num,
                                                                       longint scale,
                                                                       longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag * scale + den) / (2 * den);
    if (q > qrm_pkg::ONE_Q14) q = qrm_pkg::ONE_Q14;
    return qrm_pkg::OUT_W'((num < 0) ? -q : q);
  endfunction

  function automatic matrix_t rotation_of(logic signed [qrm_pkg::IN_W-1:0] qx_v,
                                          logic signed [qrm_pkg::IN_W-1:0] qy_v,
                                          logic signed [qrm_pkg::IN_W-1:0] qz_v,
                                          logic signed [qrm_pkg::IN_W-1:0] qw_v);
    longint x, y, z, w, xx, yy, zz, ww, n, one, two;
    matrix_t r;
    x = qx_v;
    y = qy_v;
    z = qz_v;
    w = qw_v;
    xx = x * x;
    yy = y * y;
    zz = z * z;
    ww = w * w;
    n = xx + yy + zz + ww;
    one = qrm_pkg::ONE_Q14;
    two = 2 * qrm_pkg::ONE_Q14;
    r = '0;
    if (n == 0) begin
      // zero norm: identity and flag
      r.el[0] = qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14);
      r.el[4] = qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14);
      r.el[8] = qrm_pkg::OUT_W'(qrm_pkg::ONE_Q14);
      r.zero = 1'b1;
      return r;
    end
    r.el[0] = round_ratio_q14(ww + xx - yy - zz, one, n);
    r.el[1] = round_ratio_q14(x * y - z * w, two, n);
    r.el[2] = round_ratio_q14(z * x + y * w, two, n);
    r.el[3] = round_ratio_q14(x * y + z * w, two, n);
    r.el[4] = round_ratio_q14(ww + yy - xx - zz, one, n);
    r.el[5] = round_ratio_q14(y * z - x * w, two, n);
    r.el[6] = round_ratio_q14(z * x - y * w, two, n);
    r.el[7] = round_ratio_q14(y * z + x * w, two, n);
    r.el[8] = round_ratio_q14(ww + zz - xx - yy, one, n);
    return r;
  endfunction

  initial begin
    errors = 0;
    checked = 0;
    zeros = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    matrix_t got;
    matrix_t want;
    if (!rst && start && !busy)
      expected_matrices.push_back(rotation_of(qx, qy, qz, qw));
    if (!rst && done) begin
      got.el[0] = m00;
      got.el[1] = m01;
      got.el[2] = m02;
      got.el[3] = m10;
      got.el[4] = m11;
      got.el[5] = m12;
      got.el[6] = m20;
      got.el[7] = m21;
      got.el[8] = m22;
      got.zero  = norm_zero;
      if (expected_matrices.size() == 0) begin
        $display("%0t: matrix word with none expected, got m00 %0d m11 %0d m22 %0d norm_zero %0b",
                 $time, m00, m11, m22, norm_zero);
        errors++;
      end else begin
        want = expected_matrices.pop_front();
        for (int i = 0; i < qrm_pkg::NUM_EL; i++) begin
          if (got.el[i] !== want.el[i]) begin
            $display("%0t: m%0d%0d expected %0d, got %0d", $time, i / 3, i % 3,
                     $signed(want.el[i]), $signed(got.el[i]));
            errors++;
          end
        end
        if (got.zero !== want.zero) begin
          $display("%0t: norm_zero expected %0b, got %0b", $time, want.zero, got.zero);
          errors++;
        end
        checked++;
        if (want.zero) zeros++;
      end
    end
    pending <= expected_matrices.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives quaternion words into quaternion_to_rotation_matrix: a directed set
// of corner quaternions, then random words of mixed shape with random idle
// bursts, and gives the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_WORDS = 480;
  localparam int CALM_TAIL    = 100;   // last random words sent back to back
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_CORNERS  = 22;

  logic clk, rst, start, busy, done, norm_zero;
  logic signed [qrm_pkg::IN_W-1:0]  qx, qy, qz, qw;
  logic signed [qrm_pkg::OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  int errors, checked, zeros, pending;
  int words_sent = 0;
  int cycles = 0;

  logic signed [qrm_pkg::IN_W-1:0] corner_cases [NUM_CORNERS][4] = '{
    '{0, 0, 0, 0},
    '{0, 0, 0, 16384},
    '{16384, 0, 0, 0},
    '{0, 16384, 0, 0},
    '{0, 0, 16384, 0},
    '{0, 0, 0, -16384},
    '{-32768, -32768, -32768, -32768},
    '{32767, 32767, 32767, 32767},
    '{-32768, 0, 0, 0},
    '{0, 0, 0, -32768},
    '{32767, -32768, 32767, -32768},
    '{1, 0, 0, 0},
    '{0, 0, 0, 1},
    '{1, 1, 1, 1},
    '{-1, 1, -1, 1},
    '{11585, 0, 0, 11585},
    '{0, -11585, 0, 11585},
    '{8192, 8192, 8192, 8192},
    '{-16384, 8192, -4096, 2048},
    '{3, 1, 1, 1},
    '{1, -2, 0, 0},
    '{-1, -1, -1, -1}
  };

  quaternion_to_rotation_matrix dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .qx(qx), .qy(qy), .qz(qz), .qw(qw),
    .done(done),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .norm_zero(norm_zero)
  );

  qrm_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .qx(qx), .qy(qy), .qz(qz), .qw(qw),
    .done(done),
    .m00(m00), .m01(m01), .m02(m02),
    .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .norm_zero(norm_zero),
    .errors(errors), .checked(checked), .zeros(zeros), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped at cycle %0d with %0d matrix words outstanding", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold start high until the word is taken; start stays high for a following word
  task automatic send_word(input logic signed [qrm_pkg::IN_W-1:0] x,
                           input logic signed [qrm_pkg::IN_W-1:0] y,
                           input logic signed [qrm_pkg::IN_W-1:0] z,
                           input logic signed [qrm_pkg::IN_W-1:0] w);
    qx <= x;
    qy <= y;
    qz <= z;
    qw <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // drop start for a random burst, with noise on the data lines
  task automatic maybe_idle(input bit allowed);
    int gap;
    if (allowed && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) begin
        qx <= qrm_pkg::IN_W'($urandom);
        qy <= qrm_pkg::IN_W'($urandom);
        qz <= qrm_pkg::IN_W'($urandom);
        qw <= qrm_pkg::IN_W'($urandom);
        @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [qrm_pkg::IN_W-1:0] random_component(int flavor);
    logic signed [qrm_pkg::IN_W-1:0] extremes [7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
    unique case (flavor)
      0: return qrm_pkg::IN_W'($urandom);
      1: return qrm_pkg::IN_W'($urandom_range(0, 8) - 4);
      2: return extremes[$urandom_range(0, 6)];
      default: return qrm_pkg::IN_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  initial begin
    logic signed [qrm_pkg::IN_W-1:0] c [4];
    int shape;
    int axis;
    rst <= 1'b1;
    start <= 1'b0;
    qx <= '0;
    qy <= '0;
    qz <= '0;
    qw <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < NUM_CORNERS; k++) begin
      send_word(corner_cases[k][0], corner_cases[k][1], corner_cases[k][2], corner_cases[k][3]);
      maybe_idle(1'b1);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      shape = $urandom_range(0, 99);
      if (shape < 5) begin
        c = '{0, 0, 0, 0};
      end else if (shape < 15) begin
        // one random component, the others zero
        c = '{0, 0, 0, 0};
        axis = $urandom_range(0, 3);
        c[axis] = random_component($urandom_range(0, 3));
      end else if (shape < 40) begin
        for (int j = 0; j < 4; j++) c[j] = random_component($urandom_range(0, 3));
      end else if (shape < 55) begin
        for (int j = 0; j < 4; j++) c[j] = random_component(1);
      end else begin
        for (int j = 0; j < 4; j++) c[j] = random_component(0);
      end
      send_word(c[0], c[1], c[2], c[3]);
      maybe_idle(i < RANDOM_WORDS - CALM_TAIL);
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d quaternion words (corners, small, extreme and full-range values);",
             words_sent);
    $display("checked %0d matrix words, %0d of them zero-norm identity.", checked, zeros);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> quaternion_to_rotation_matrix.f
sv/qrm_pkg.sv
sv/qrm_front.sv
sv/qrm_div_step.sv
sv/qrm_back.sv
sv/quaternion_to_rotation_matrix.sv
bench/qrm_checker.sv
bench/tb_top.sv
